// ----- hw/rtl/ttns_pkg.sv -----
// Shared types and constants for the tick to nanosecond scaler.
// No dependencies.
package ttns_pkg;

  localparam int unsigned HalfW = 32;
  localparam int unsigned FullW = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [HalfW-1:0] DefaultScale = 32'd1000000000;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgScaleMult  = 2'd0,
    CfgScaleDiv   = 2'd1,
    CfgNsecOffset = 2'd2,
    CfgUnused     = 2'd3
  } cfg_idx_e;

endpackage

// ----- hw/rtl/ttns_div.sv -----
// Pipelined 64 by 32 bit restoring divider, one quotient bit per stage.
// Depends on ttns_pkg. A 64-bit sideband word travels with each request.
module ttns_div import ttns_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [HalfW-1:0] den_i,
  input  logic             vld_i,
  input  logic [FullW-1:0] num_i,
  input  logic [FullW-1:0] side_i,
  output logic             vld_o,
  output logic [FullW-1:0] quot_o,
  output logic [HalfW-1:0] rem_o,
  output logic [FullW-1:0] side_o
);

  // Per stage: partial remainder, numerator bits left / quotient bits in
  logic             vld_q  [FullW];
  logic [HalfW-1:0] rem_q  [FullW];
  logic [FullW-1:0] nq_q   [FullW];
  logic [FullW-1:0] side_q [FullW];

  for (genvar k = 0; k < FullW; k++) begin : g_stage
    logic             vld_in;
    logic [HalfW-1:0] rem_in;
    logic [FullW-1:0] nq_in;
    logic [FullW-1:0] side_in;
    logic [HalfW:0]   trial;
    logic             qbit;
    logic [HalfW-1:0] rem_d;
    logic [FullW-1:0] nq_d;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Shift in next numerator bit, subtract divisor if it fits
    assign trial = {rem_in, nq_in[FullW-1]};
    assign qbit  = (trial >= {1'b0, den_i});
    assign rem_d = qbit ? HalfW'(trial - {1'b0, den_i}) : trial[HalfW-1:0];
    assign nq_d  = {nq_in[FullW-2:0], qbit};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        nq_q[k]   <= nq_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[FullW-1];
  assign quot_o = nq_q[FullW-1];
  assign rem_o  = rem_q[FullW-1];
  assign side_o = side_q[FullW-1];

endmodule

// ----- hw/rtl/tick_to_nsec_scaler.sv -----
// Top level of the tick to nanosecond scaler: ticks * mult / div + offset.
// Depends on ttns_pkg and ttns_div.
//
//   channel  | handshake                     | payload
//   tick     | tick_valid_i / tick_ready_o   | tick_count_i[63:0]
//   nsec     | nsec_valid_o / nsec_ready_i   | nsec_time_o[63:0]
//   config   | cfg_we_i (no wait)            | cfg_idx_i, cfg_wdata_i
//
// One request enters every cycle while the pipeline advances; the stages are a multiply stage,
// 64 divider stages, a multiply-add stage, 64 divider stages, the output add.
// The pipeline depth is set by the two one-bit-per-stage dividers.
// When the output register is full and not taken, the whole pipeline holds.
// Reset clears all valid bits and loads the default scale and zero offset.
module tick_to_nsec_scaler import ttns_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [FullW-1:0]   cfg_wdata_i,
  input  logic               tick_valid_i,
  output logic               tick_ready_o,
  input  logic [FullW-1:0]   tick_count_i,
  output logic               nsec_valid_o,
  input  logic               nsec_ready_i,
  output logic [FullW-1:0]   nsec_time_o
);

  logic [HalfW-1:0] scale_mult_q;
  logic [HalfW-1:0] scale_div_q;
  logic [FullW-1:0] nsec_offset_q;
  logic             adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_mult_q  <= DefaultScale;
      scale_div_q   <= DefaultScale;
      nsec_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgScaleMult:  scale_mult_q  <= cfg_wdata_i[HalfW-1:0];
        CfgScaleDiv:   scale_div_q   <= cfg_wdata_i[HalfW-1:0];
        CfgNsecOffset: nsec_offset_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // Pipeline advances unless the output holds an untaken result
  logic             out_vld_q;
  logic [FullW-1:0] out_q;
  assign adv          = !out_vld_q || nsec_ready_i;
  assign tick_ready_o = adv;

  // Stage 1: upper half times mult
  logic             s1_vld_q;
  logic [FullW-1:0] s1_prod_q;
  logic [HalfW-1:0] s1_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= tick_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q <= tick_count_i[FullW-1:HalfW] * scale_mult_q;
      s1_low_q  <= tick_count_i[HalfW-1:0];
    end
  end

  // First division: upper product by div
  logic             da_vld;
  logic [FullW-1:0] da_quot;
  logic [HalfW-1:0] da_rem;
  logic [FullW-1:0] da_side;

  ttns_div u_div_hi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .den_i  (scale_div_q),
    .vld_i  (s1_vld_q),
    .num_i  (s1_prod_q),
    .side_i ({{HalfW{1'b0}}, s1_low_q}),
    .vld_o  (da_vld),
    .quot_o (da_quot),
    .rem_o  (da_rem),
    .side_o (da_side)
  );

  // Stage 2: lower half times mult plus remainder shifted up, wraps mod 2^64
  logic             s2_vld_q;
  logic [FullW-1:0] s2_sum_q;
  logic [FullW-1:0] s2_hq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= da_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sum_q <= (da_side[HalfW-1:0] * scale_mult_q) + {da_rem, {HalfW{1'b0}}};
      s2_hq_q  <= da_quot;
    end
  end

  // Second division: lower sum by div, upper quotient as sideband
  logic             db_vld;
  logic [FullW-1:0] db_quot;
  logic [HalfW-1:0] db_rem;
  logic [FullW-1:0] db_side;

  ttns_div u_div_lo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .den_i  (scale_div_q),
    .vld_i  (s2_vld_q),
    .num_i  (s2_sum_q),
    .side_i (s2_hq_q),
    .vld_o  (db_vld),
    .quot_o (db_quot),
    .rem_o  (db_rem),
    .side_o (db_side)
  );

  // Output stage: join quotients and add offset
  logic [FullW-1:0] out_d;
  assign out_d = {db_side[HalfW-1:0], {HalfW{1'b0}}} + db_quot + nsec_offset_q
               + FullW'(db_rem & '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= db_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign nsec_valid_o = out_vld_q;
  assign nsec_time_o  = out_q;

endmodule

// ----- dv/tb.sv -----
// Testbench for tick_to_nsec_scaler: random and directed tick requests with a
// class-based scoreboard that predicts ticks * mult / div + offset.
// Depends on ttns_pkg and the scaler RTL.
module tb;
  import ttns_pkg::*;

  localparam int unsigned Latency = 131;
  localparam longint unsigned CycleLimit = 400000;

  // Scoreboard: expected conversions in order, using the current settings
  class nsec_scoreboard;
    logic [63:0] mult_q = 64'(DefaultScale);
    logic [63:0] div_q  = 64'(DefaultScale);
    logic [63:0] offs_q = '0;
    logic [63:0] pending[$];
    int errors = 0;
    int checked = 0;

    function void set_reg(cfg_idx_e idx, logic [63:0] val);
      case (idx)
        CfgScaleMult:  mult_q = {32'd0, val[31:0]};
        CfgScaleDiv:   div_q  = {32'd0, val[31:0]};
        CfgNsecOffset: offs_q = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] qdiv(logic [63:0] n, logic [63:0] d);
      return (d == 0) ? '1 : n / d;
    endfunction

    function logic [63:0] qrem(logic [63:0] n, logic [63:0] d);
      return (d == 0) ? n : n % d;
    endfunction

    function void note_tick(logic [63:0] ticks);
      logic [63:0] hi_prod, hi_quot, hi_rem, lo_sum, lo_quot;
      hi_prod = {32'd0, ticks[63:32]} * mult_q;
      hi_quot = qdiv(hi_prod, div_q);
      hi_rem  = qrem(hi_prod, div_q);
      lo_sum  = {32'd0, ticks[31:0]} * mult_q + (hi_rem << 32);
      lo_quot = qdiv(lo_sum, div_q);
      pending.push_back((hi_quot << 32) + lo_quot + offs_q);
    endfunction

    function void check_nsec(logic [63:0] got);
      logic [63:0] exp_v;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected nsec result %h", got);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got !== exp_v) begin
        $error("nsec_time mismatch: expected %h actual %h", exp_v, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = CfgScaleMult;
  logic [63:0] cfg_wdata_i = '0;
  logic tick_valid_i = 1'b0;
  logic tick_ready_o;
  logic [63:0] tick_count_i = '0;
  logic nsec_valid_o;
  logic nsec_ready_i = 1'b0;
  logic [63:0] nsec_time_o;

  nsec_scoreboard sb = new();
  longint unsigned cycles = 0;
  int hold_off = 0;
  int long_req = 0;
  int long_seen = 0;
  int n_sent = 0;

  tick_to_nsec_scaler u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .tick_valid_i, .tick_ready_o, .tick_count_i,
    .nsec_valid_o, .nsec_ready_i, .nsec_time_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result checker and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && nsec_valid_o && nsec_ready_i) sb.check_nsec(nsec_time_o);
    if (hold_off > 0) begin
      nsec_ready_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      nsec_ready_i <= 1'b1;
    end else begin
      nsec_ready_i <= ($urandom_range(0, 9) != 0);
    end
    // long stall on request from the sender, else short random ones
    if (long_req != long_seen) begin
      long_seen <= long_req;
      hold_off <= 300;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end else if ($urandom_range(0, 199) == 0) begin
      hold_off <= $urandom_range(20, 60);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one tick request; stays valid until accepted
  task automatic send_tick(logic [63:0] ticks, bit gaps);
    int gap;
    gap = 0;
    if (gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end
    if (gap > 0) begin
      tick_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_valid_i <= 1'b1;
    tick_count_i <= ticks;
    do @(posedge clk_i); while (!tick_ready_o);
    sb.note_tick(ticks);
    n_sent++;
  endtask

  task automatic drain();
    tick_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = '1;
      2: v = {32'd0, v[31:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic rand_phase(int n);
    // most items back to back or short gaps; one long receiver stall per phase
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) long_req++;
      send_tick(rand64(), $urandom_range(0, 2) != 0);
    end
    drain();
  endtask

  initial begin
    logic [63:0] edge_ticks[6];
    edge_ticks = '{64'd0, 64'd1, 64'hffff_ffff, 64'h1_0000_0000, '1,
                   64'h5555_5555_aaaa_aaaa};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default scale, then extreme ratios and offsets
    foreach (edge_ticks[i]) send_tick(edge_ticks[i], 1'b0);
    drain();
    write_reg(CfgScaleMult, 64'hffff_ffff_ffff_ffff);
    write_reg(CfgScaleDiv, 64'h1);
    write_reg(CfgNsecOffset, '1);
    foreach (edge_ticks[i]) send_tick(edge_ticks[i], 1'b0);
    drain();
    write_reg(CfgScaleMult, 64'h1);
    write_reg(CfgScaleDiv, 64'hffff_ffff);
    write_reg(CfgUnused, 64'h1234);
    foreach (edge_ticks[i]) send_tick(edge_ticks[i], 1'b0);
    drain();

    // Random settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CfgScaleMult, {$urandom(), ($urandom_range(0, 3) == 0) ? 32'd1 : $urandom()});
      write_reg(CfgScaleDiv, {$urandom(), 32'($urandom_range(1, 32'hffff_ffff))});
      write_reg(CfgNsecOffset, rand64());
      rand_phase(100);
    end

    $display("Converted %0d tick requests, checked %0d results over 9 scale settings.",
             n_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
